// ----- hw/rtl/visited_pose_proximity_filter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Visited pose proximity filter - assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef VISITED_POSE_PROXIMITY_FILTER_CORE_DEFINES_SVH
`define VISITED_POSE_PROXIMITY_FILTER_CORE_DEFINES_SVH

// check outside reset
`define VPPF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define VPPF_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/vppf_pkg.sv -----
// ----------------------------------------------------------------------------
// Visited pose proximity filter - package
// Beat types, controller states and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vppf_pkg;

  localparam int unsigned POS_W     = 20;
  localparam int unsigned RADIUS_W  = 16;
  localparam int unsigned ENTRIES_W = 9;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd500;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } in_t;

  typedef struct packed {
    logic                 is_new;
    logic                 stored;
    logic [ENTRIES_W-1:0] entries;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_rd;
  } stat_t;

endpackage

// ----- hw/rtl/vppf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Visited pose proximity filter - controller
// Sequences load, store scan, pipeline drain and commit of one query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vppf_ctrl import vppf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = stat.empty ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:   cmd.rd_en  = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_FINISH: cmd.commit = 1'b1;
      default:   cmd        = '0;
    endcase
  end

endmodule

// ----- hw/rtl/vppf_datapath.sv -----
// ----------------------------------------------------------------------------
// Visited pose proximity filter - datapath
// Position store, box compare, entry count, radius register and result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vppf_datapath import vppf_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  in_t                 in_data,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_wdata,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic                out_valid,
  output out_t                out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [2*POS_W-1:0]  mem [CAPACITY];

  in_t                 q_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [AW-1:0]       idx_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                rd_vld_r;
  logic [2*POS_W-1:0]  rd_data_r;
  logic                hit_r;
  logic                out_valid_r;
  out_t                out_r;

  logic signed [POS_W+1:0] qx, qy, sx, sy, dx, dy, rad_p, rad_n;
  logic                    cov;
  logic                    put;

  // box compare against the entry read last cycle
  always_comb begin
    qx    = {{2{q_r.pos_x[POS_W-1]}}, q_r.pos_x};
    qy    = {{2{q_r.pos_y[POS_W-1]}}, q_r.pos_y};
    sx    = {{2{rd_data_r[2*POS_W-1]}}, rd_data_r[2*POS_W-1:POS_W]};
    sy    = {{2{rd_data_r[POS_W-1]}}, rd_data_r[POS_W-1:0]};
    dx    = qx - sx;
    dy    = qy - sy;
    rad_p = {{(POS_W+2-RADIUS_W){1'b0}}, radius_r};
    rad_n = -rad_p;
    cov   = (dx <= rad_p) && (dx >= rad_n) && (dy <= rad_p) && (dy >= rad_n);
  end

  assign put       = !hit_r && (count_r < CAP_CNT);
  assign count_nxt = count_r + CW'(put);

  assign stat.empty   = (count_r == '0);
  assign stat.last_rd = ((CW'(idx_r) + CW'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      rd_vld_r    <= cmd.rd_en;
      out_valid_r <= cmd.commit;
      if (cmd.load) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          idx_r <= idx_r + AW'(1);
        end
        if (rd_vld_r && cov) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r <= in_data;
    end
    if (cmd.commit) begin
      out_r.is_new  <= !hit_r;
      out_r.stored  <= put;
      out_r.entries <= ENTRIES_W'(count_nxt);
    end
  end

  // position store
  always_ff @(posedge clk) begin
    if (cmd.commit && put) begin
      mem[count_r[AW-1:0]] <= {q_r.pos_x, q_r.pos_y};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/visited_pose_proximity_filter_core.sv -----
// ----------------------------------------------------------------------------
// Visited pose proximity filter - top level
// Flags a position as new unless a stored position lies within the square
// box of half-width radius on both axes; new positions are appended while
// the store has room.
// ----------------------------------------------------------------------------
// A query is taken when start is high and busy is low. The scan reads one
// stored position per cycle through the single read port of the store,
// then a drain state empties the compare; on an empty store both are
// skipped. A finish state then commits the append, after which busy falls
// and the next start can be taken. The result beat appears on
// out_data with out_valid high for one cycle right after busy falls and
// cannot be stalled; start may be raised in that same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "visited_pose_proximity_filter_core_defines.svh"

module visited_pose_proximity_filter_core import vppf_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_t                 in_data,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_wdata,
  output logic                out_valid,
  output out_t                out_data
);

  cmd_t  cmd;
  stat_t stat;

  vppf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  vppf_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `VPPF_ASSERT_RST(a_accept_busy, start && !busy |=> busy, "accepted beat did not raise busy")
  `VPPF_ASSERT_RST(a_commit_out, cmd.commit |=> out_valid && !busy, "commit without result beat")
  `VPPF_ASSERT_RST(a_out_idle, out_valid |-> $past(cmd.commit), "result beat without commit")
  `VPPF_ASSERT_ALL(a_entries_cap, out_valid |-> (out_data.entries <= CAPACITY), "entries beyond capacity")

endmodule
